FILE: design/debounced_pulse_width_meter_macros.svh
// Assertion macros used by the pulse width meter top level.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef DEBOUNCED_PULSE_WIDTH_METER_MACROS_SVH
`define DEBOUNCED_PULSE_WIDTH_METER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DPWM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DPWM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: design/dpwm_pkg.sv
// Package for the debounced pulse width meter: beat types and fixed constants.
// Depends on nothing; used by the top level by scoped names.
`timescale 1ns / 1ps

package dpwm_pkg;

   localparam int unsigned CountWidth = 16;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [CountWidth-1:0] TIMER_INIT_RESET = 16'hFFFF;

   typedef struct packed {
      logic                  req_type;
      logic                  pin_sample;
      logic [CountWidth-1:0] pulse_count;
   } req_beat_type;

   typedef struct packed {
      logic                  level;
      logic                  measuring;
      logic                  done_res;
      logic [CountWidth-1:0] live_ms;
      logic [CountWidth-1:0] width_ms;
      logic [CountWidth-1:0] pulse_delta;
   } rsp_beat_type;

endpackage

FILE: design/debounced_pulse_width_meter.sv
// Top level of the debounced pulse width meter: debounce, timing and output buffering.
// Depends on dpwm_pkg and debounced_pulse_width_meter_macros.svh.
//
// Each request beat is either a one-millisecond tick carrying a raw pin sample
// and the external pulse counter value, or a clear of the current measurement.
// Every request beat gives exactly one response beat with the debounced level,
// the measuring and done flags, the live duration, the last pulse width and
// the pulse count difference.
// The state is updated in the cycle a request is accepted. The response is registered
// in the output register, or in the skid register while that one is held. One request
// is accepted per cycle while req_stall is low, as set by the single state update path.
// When the receiver stalls, the response holds in the output register and one
// more response is caught in a skid register; req_stall rises only while that
// skid register is full, so no beat is lost.
// The timer_init register is written on the csr channel, which is always ready.
// Synchronous reset clears all flags, durations and counters, loads the
// history with only its top bit set and sets timer_init to 65535.
`timescale 1ns / 1ps
`include "debounced_pulse_width_meter_macros.svh"

module debounced_pulse_width_meter #(
   parameter int unsigned HISTORY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dpwm_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dpwm_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [dpwm_pkg::CountWidth-1:0] csr_wdata
);

   localparam logic [HISTORY_BITS-1:0] HistReset = HISTORY_BITS'(1) << (HISTORY_BITS - 1);

   logic [dpwm_pkg::CountWidth-1:0] timer_init_ff;
   logic [HISTORY_BITS-1:0]         history_ff, history_in;
   logic                            level_ff, level_in;
   logic                            measuring_ff, measuring_in;
   logic                            done_ff, done_in;
   logic [dpwm_pkg::CountWidth-1:0] countdown_ff, countdown_in;
   logic [dpwm_pkg::CountWidth-1:0] live_ff, live_in;
   logic [dpwm_pkg::CountWidth-1:0] width_ff, width_in;
   logic [dpwm_pkg::CountWidth-1:0] start_ff, start_in;
   logic [dpwm_pkg::CountWidth-1:0] delta_ff, delta_in;
   logic [dpwm_pkg::CountWidth-1:0] count_dec;
   logic [dpwm_pkg::CountWidth-1:0] elapsed;

   dpwm_pkg::rsp_beat_type result;
   dpwm_pkg::rsp_beat_type out_ff;
   dpwm_pkg::rsp_beat_type skid_ff;
   logic                   out_valid_ff;
   logic                   skid_valid_ff;
   logic                   req_accept;
   logic                   rsp_take;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   always_comb begin
      count_dec    = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;
      elapsed      = timer_init_ff - count_dec;
      history_in   = history_ff;
      level_in     = level_ff;
      measuring_in = measuring_ff;
      done_in      = done_ff;
      countdown_in = countdown_ff;
      live_in      = live_ff;
      width_in     = width_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      if (req_data.req_type == dpwm_pkg::REQ_CLEAR) begin
         done_in      = 1'b0;
         width_in     = '0;
         measuring_in = 1'b0;
         countdown_in = timer_init_ff;
         live_in      = '0;
      end else begin
         countdown_in = count_dec;
         history_in   = {history_ff[HISTORY_BITS-2:0], req_data.pin_sample};
         if (&history_in) begin
            level_in = 1'b1;
         end else if (history_in == '0) begin
            level_in = 1'b0;
         end
         if (level_in && !measuring_ff) begin
            start_in     = req_data.pulse_count;
            measuring_in = 1'b1;
            countdown_in = timer_init_ff;
            done_in      = 1'b0;
            live_in      = '0;
         end else if (level_in && measuring_ff) begin
            live_in = elapsed;
         end else if (!level_in && measuring_ff) begin
            delta_in     = req_data.pulse_count - start_ff;
            width_in     = elapsed;
            measuring_in = 1'b0;
            live_in      = '0;
            done_in      = 1'b1;
         end
      end
      result.level       = level_in;
      result.measuring   = measuring_in;
      result.done_res    = done_in;
      result.live_ms     = live_in;
      result.width_ms    = width_in;
      result.pulse_delta = delta_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_init_ff <= dpwm_pkg::TIMER_INIT_RESET;
         history_ff    <= HistReset;
         level_ff      <= 1'b0;
         measuring_ff  <= 1'b0;
         done_ff       <= 1'b0;
         countdown_ff  <= '0;
         live_ff       <= '0;
         width_ff      <= '0;
         start_ff      <= '0;
         delta_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            timer_init_ff <= csr_wdata;
         end
         if (req_accept) begin
            history_ff   <= history_in;
            level_ff     <= level_in;
            measuring_ff <= measuring_in;
            done_ff      <= done_in;
            countdown_ff <= countdown_in;
            live_ff      <= live_in;
            width_ff     <= width_in;
            start_ff     <= start_in;
            delta_ff     <= delta_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            out_ff <= result;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   `DPWM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid beat without output beat")
   `DPWM_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_valid && !req_stall, rsp_valid,
      "accepted beat gave no response")
   `DPWM_ASSERT_NOW(a_measuring_level, clock, reset, rsp_valid && rsp_data.measuring,
      rsp_data.level, "measuring while level inactive")
   `DPWM_ASSERT_NOW(a_live_measuring, clock, reset, rsp_valid && rsp_data.live_ms != '0,
      rsp_data.measuring, "live duration outside a measurement")

endmodule

FILE: test/tb_debounced_pulse_width_meter.sv
`timescale 1ns / 1ps
// Testbench for debounced_pulse_width_meter: a directed table, then random pulse trains under
// several timer settings, every beat checked against a behavioral predictor or its typed row.
// Depends on dpwm_pkg and the debounced_pulse_width_meter RTL.

module tb_debounced_pulse_width_meter;

   localparam int HIST_BITS = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_SETTING = 250;
   localparam int NUM_SETTINGS = 7;
   localparam int HOLD_CYCLES = 60;

   localparam dpwm_pkg::rsp_beat_type ZERO_RSP = '0;
   localparam dpwm_pkg::rsp_beat_type LEVEL_ONLY_RSP = {1'b1, 50'd0};

   typedef struct packed {
      dpwm_pkg::req_beat_type beat;
      logic                   typed;
      dpwm_pkg::rsp_beat_type want;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   dpwm_pkg::req_beat_type          req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   dpwm_pkg::rsp_beat_type          rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [dpwm_pkg::CountWidth-1:0] csr_wdata = '0;

   logic [HIST_BITS-1:0]            hist_m = {1'b1, {(HIST_BITS-1){1'b0}}};
   logic                            level_m = 1'b0;
   logic                            measuring_m = 1'b0;
   logic                            done_m = 1'b0;
   logic [dpwm_pkg::CountWidth-1:0] countdown_m = '0;
   logic [dpwm_pkg::CountWidth-1:0] live_m = '0;
   logic [dpwm_pkg::CountWidth-1:0] width_m = '0;
   logic [dpwm_pkg::CountWidth-1:0] start_m = '0;
   logic [dpwm_pkg::CountWidth-1:0] delta_m = '0;
   logic [dpwm_pkg::CountWidth-1:0] timer_m = dpwm_pkg::TIMER_INIT_RESET;

   dpwm_pkg::rsp_beat_type expected_status_q[$];

   int  cycle_count = 0;
   int  error_count = 0;
   int  req_accepted = 0;
   int  rsp_checked = 0;
   int  pulses_done = 0;
   int  clears_seen = 0;
   int  stalled_input_cycles = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  quiet_mode = 1'b0;

   logic                            run_level = 1'b0;
   int                              run_left = 0;
   logic [dpwm_pkg::CountWidth-1:0] pulse_ctr = '0;

   logic [dpwm_pkg::CountWidth-1:0] timer_settings [0:NUM_SETTINGS-1] =
      '{16'h0000, 16'h0001, 16'h0014, 16'hFFFF, 16'h0000, 16'h0003, 16'h0000};

   dir_row_type dir_rows [0:21] = '{
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0000, 1'b1, ZERO_RSP},
      {dpwm_pkg::REQ_CLEAR, 1'b1, 16'hFFFF, 1'b1, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0001, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0002, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0003, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0004, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0005, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0006, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'h0007, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'hFFF0, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'hFFF2, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'hFFF4, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_CLEAR, 1'b0, 16'h1234, 1'b1, LEVEL_ONLY_RSP},
      {dpwm_pkg::REQ_TICK,  1'b1, 16'hFFFF, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0000, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0000, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0001, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0001, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0002, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0003, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0004, 1'b0, ZERO_RSP},
      {dpwm_pkg::REQ_TICK,  1'b0, 16'h0005, 1'b0, ZERO_RSP}
   };

   debounced_pulse_width_meter #(
      .HISTORY_BITS(HIST_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_stall) begin
         stalled_input_cycles <= stalled_input_cycles + 1;
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding.", cycle_count,
                  expected_status_q.size());
         $display("debounced_pulse_width_meter regression: fail");
         $finish;
      end
   end

   function automatic dpwm_pkg::rsp_beat_type predict_meter_status(
      input dpwm_pkg::req_beat_type b);
      dpwm_pkg::rsp_beat_type r;
      if (b.req_type == dpwm_pkg::REQ_TICK) begin
         if (countdown_m != 0) begin
            countdown_m = countdown_m - 1'b1;
         end
         hist_m = {hist_m[HIST_BITS-2:0], b.pin_sample};
         if (&hist_m) begin
            level_m = 1'b1;
         end else if (hist_m == '0) begin
            level_m = 1'b0;
         end
         if (level_m && !measuring_m) begin
            start_m = b.pulse_count;
            measuring_m = 1'b1;
            countdown_m = timer_m;
            done_m = 1'b0;
            live_m = '0;
         end else if (level_m && measuring_m) begin
            live_m = timer_m - countdown_m;
         end else if (!level_m && measuring_m) begin
            delta_m = b.pulse_count - start_m;
            width_m = timer_m - countdown_m;
            measuring_m = 1'b0;
            live_m = '0;
            done_m = 1'b1;
            pulses_done++;
         end
      end else begin
         done_m = 1'b0;
         width_m = '0;
         measuring_m = 1'b0;
         countdown_m = timer_m;
         live_m = '0;
         clears_seen++;
      end
      r.level = level_m;
      r.measuring = measuring_m;
      r.done_res = done_m;
      r.live_ms = live_m;
      r.width_ms = width_m;
      r.pulse_delta = delta_m;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("beat %0d %s got %0d want %0d", rsp_checked, name, got,
                                   want));
      end
   endtask

   task automatic check_status(input dpwm_pkg::rsp_beat_type got);
      dpwm_pkg::rsp_beat_type want;
      if (expected_status_q.size() == 0) begin
         report_mismatch("response beat with no request outstanding");
         return;
      end
      want = expected_status_q.pop_front();
      rsp_checked++;
      compare_field("level", 16'(got.level), 16'(want.level));
      compare_field("measuring", 16'(got.measuring), 16'(want.measuring));
      compare_field("done_res", 16'(got.done_res), 16'(want.done_res));
      compare_field("live_ms", got.live_ms, want.live_ms);
      compare_field("width_ms", got.width_ms, want.width_ms);
      compare_field("pulse_delta", got.pulse_delta, want.pulse_delta);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_status(rsp_data);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(99) < 21);
         end
      end
   end

   task automatic send_req(input dpwm_pkg::req_beat_type b, input logic typed,
                           input dpwm_pkg::rsp_beat_type want);
      dpwm_pkg::rsp_beat_type predicted;
      while (!quiet_mode && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      req_accepted++;
      predicted = predict_meter_status(b);
      expected_status_q.push_back(typed ? want : predicted);
   endtask

   task automatic write_timer_init(input logic [dpwm_pkg::CountWidth-1:0] value);
      wait (expected_status_q.size() == 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      timer_m = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_pulse_trains(input int n, input bit pressure);
      dpwm_pkg::req_beat_type b;
      int                     pick;
      for (int i = 0; i < n; i++) begin
         if (pressure && i == 80) begin
            hold_request = 1'b1;
         end
         if (pressure && i == 160) begin
            req_valid <= 1'b0;
            wait (expected_status_q.size() == 0);
            @(posedge clock);
         end
         pick = $urandom_range(99);
         pulse_ctr = pulse_ctr + 16'($urandom_range(0, 300));
         if ($urandom_range(99) < 2) begin
            pulse_ctr = 16'($urandom);
         end
         if (pick < 3) begin
            b.req_type = dpwm_pkg::REQ_CLEAR;
            b.pin_sample = 1'($urandom_range(1));
            b.pulse_count = 16'($urandom);
         end else if (pick < 9) begin
            b.req_type = dpwm_pkg::REQ_TICK;
            b.pin_sample = 1'($urandom_range(1));
            b.pulse_count = 16'($urandom);
         end else begin
            if (run_left == 0) begin
               run_level = !run_level;
               run_left = ($urandom_range(99) < 80) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 7);
            end
            run_left--;
            b.req_type = dpwm_pkg::REQ_TICK;
            b.pin_sample = run_level;
            b.pulse_count = pulse_ctr;
         end
         send_req(b, 1'b0, ZERO_RSP);
      end
   endtask

   initial begin
      timer_settings[4] = 16'($urandom);
      timer_settings[6] = 16'($urandom_range(2, 64));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[k]) begin
         send_req(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
      end
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         req_valid <= 1'b0;
         write_timer_init(timer_settings[p]);
         quiet_mode = (p == 2);
         run_pulse_trains(RANDOM_PER_SETTING, p == 3);
      end
      req_valid <= 1'b0;
      quiet_mode = 1'b0;
      wait (expected_status_q.size() == 0);
      repeat (10) @(posedge clock);
      $display("Covered %0d request beats and %0d checked responses over %0d timer settings.",
               req_accepted, rsp_checked, NUM_SETTINGS);
      $display("Saw %0d completed pulses, %0d clears, %0d input stall cycles; %0d mismatches.",
               pulses_done, clears_seen, stalled_input_cycles, error_count);
      if (error_count == 0) begin
         $display("debounced_pulse_width_meter regression: pass");
      end else begin
         $display("debounced_pulse_width_meter regression: fail");
      end
      $finish;
   end

endmodule
